// ===== rtl/core/rem_pkg.sv =====
// ----------------------------------------------------------------------------
// rem_pkg
// Shared types and constants of the rumble effect mixer.
// ----------------------------------------------------------------------------
package rem_pkg;

  localparam int SlotCount  = 8;
  localparam int SpareBegin = 4;
  localparam int TimeBits   = 48;
  localparam int SlotBits   = $clog2(SlotCount);
  localparam int GainBits   = 17;

  localparam logic [7:0]  StrengthReset = 8'd100;
  localparam logic [4:0]  EnableReset   = 5'd31;
  localparam logic [63:0] HitReset   = 64'd11259115032550113350;
  localparam logic [63:0] HurtReset  = 64'd7881522686209228905;
  localparam logic [63:0] FireReset  = 64'd5770299299600465975;
  localparam logic [63:0] MeleeReset = 64'd16044254061143326800;

  typedef enum logic [2:0] {
    CFG_STRENGTH = 3'd0,
    CFG_ENABLE   = 3'd1,
    CFG_HIT      = 3'd2,
    CFG_HURT     = 3'd3,
    CFG_FIRE     = 3'd4,
    CFG_MELEE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_TRIGGER = 2'd1,
    ACT_MANUAL  = 2'd2,
    ACT_STOP    = 2'd3
  } action_e;

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_HURT  = 2'd1;
  localparam logic [1:0] KIND_FIRE  = 2'd2;
  localparam logic [1:0] KIND_MELEE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_GAIN, ST_DIV, ST_CURVE1, ST_CURVE2, ST_ACC,
    ST_SCALE1, ST_SCALE2, ST_ISSUE, ST_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;        // latch input item, do disconnect edge
    logic store_slot;  // write trigger into its slot
    logic clear_all;   // drop all slots
    logic set_ovr;
    logic clr_ovr;
    logic clr_sum;
    logic slot_gain;   // evaluate slot gain preconditions
    logic div_step;
    logic curve1;
    logic curve2;
    logic acc;         // accumulate current slot
    logic clear_exp;   // drop expired slots
    logic scale1;
    logic scale2;
    logic issue_mix;
    logic issue_manual;
    logic issue_zero;
    logic set_rej;
    logic out_load;
    logic next_slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       master;
    logic       kind_on;
    logic       conn;
    logic       ovr;
    logic       gain_direct; // gain needs no divide
    logic       div_last;
    logic       last_slot;
  } status_t;

endpackage

// ===== rtl/core/rumble_effect_mixer_top.sv =====
// ----------------------------------------------------------------------------
// rumble_effect_mixer_top
// Two-motor rumble mixer with timed, faded effect slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one action item per
//   transfer: tick, trigger, manual drive or stop. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per item.
//   Items are handled one at a time. A tick or trigger walks all eight
//   slots through one shared serial divider and a smoothstep stage pair
//   when the master enable is on, no override holds, the pad is connected
//   and, for a trigger, its kind is enabled; the divider runs only for
//   fading slots. Stop, manual and rejected items skip the walk.
//   The result sits in an output register; the next item is accepted once
//   that result is loaded, even while it waits to be taken. When the output
//   stalls with a result still held, the sequencer holds in its last step.
//   Reset clears all slots, the drive cache and the override flag, and
//   restores the register defaults. Write configuration only while idle.
// ----------------------------------------------------------------------------
module rumble_effect_mixer_top import rem_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  effect_kind_i,
  input  logic [47:0] now_ms_i,
  input  logic        connected_i,
  input  logic [15:0] manual_left_i,
  input  logic [15:0] manual_right_i,
  input  logic [1:0]  manual_select_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] left_drive_o,
  output logic [15:0] right_drive_o,
  output logic        sent_o,
  output logic        vibrating_o,
  output logic        manual_mode_o,
  output logic        rejected_o
);

  cmd_t    cmd;
  status_t st;
  logic    out_valid_q;
  logic    out_busy;

  // Output register is busy while it holds a result not yet taken.
  assign out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end
  assign out_valid_o = out_valid_q;

  rem_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(out_busy), .st_i(st), .cmd_o(cmd)
  );

  rem_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .action_i, .effect_kind_i, .now_ms_i, .connected_i,
    .manual_left_i, .manual_right_i, .manual_select_i,
    .cmd_i(cmd), .st_o(st),
    .left_drive_o, .right_drive_o, .sent_o, .vibrating_o,
    .manual_mode_o, .rejected_o
  );

  // Never load a new result over one still being held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten");

  // Held result stays put while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(left_drive_o)))
    else $error("stalled result changed");

  // Input is taken only when the sequencer is idle.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |-> (in_valid_i && !in_stall_o))
    else $error("take without transfer");

endmodule

// ===== rtl/core/rem_ctrl.sv =====
// ----------------------------------------------------------------------------
// rem_ctrl
// Sequencer: runs each item, with the slot walk and shared divider if needed.
// ----------------------------------------------------------------------------
module rem_ctrl import rem_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    out_busy_i,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PREP;
      ST_PREP: begin
        unique case (st_i.action)
          ACT_TICK: state_d = (st_i.master && !st_i.ovr && st_i.conn) ? ST_GAIN : ST_DONE;
          ACT_TRIGGER: begin
            if (!st_i.master || !st_i.kind_on || !st_i.conn) state_d = ST_DONE;
            else if (st_i.ovr) state_d = ST_DONE;
            else state_d = ST_GAIN;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_GAIN:   state_d = st_i.gain_direct ? ST_ACC : ST_DIV;
      ST_DIV:    if (st_i.div_last) state_d = ST_CURVE1;
      ST_CURVE1: state_d = ST_CURVE2;
      ST_CURVE2: state_d = ST_ACC;
      ST_ACC:    state_d = st_i.last_slot ? ST_SCALE1 : ST_GAIN;
      ST_SCALE1: state_d = ST_SCALE2;
      ST_SCALE2: state_d = ST_ISSUE;
      ST_ISSUE:  state_d = ST_DONE;
      ST_DONE:   if (!out_busy_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.take = in_valid_i;
      ST_PREP: begin
        cmd_o.clr_sum = 1'b1;
        unique case (st_i.action)
          ACT_TICK: cmd_o.clear_exp = st_i.master && !st_i.ovr && !st_i.conn;
          ACT_TRIGGER: begin
            if (!st_i.master || !st_i.kind_on || !st_i.conn) cmd_o.set_rej = 1'b1;
            else cmd_o.store_slot = 1'b1;
          end
          ACT_MANUAL: begin
            if (!st_i.conn) cmd_o.set_rej = 1'b1;
            else begin
              cmd_o.clear_all    = 1'b1;
              cmd_o.set_ovr      = 1'b1;
              cmd_o.issue_manual = 1'b1;
            end
          end
          default: begin
            cmd_o.clr_ovr    = 1'b1;
            cmd_o.clear_all  = 1'b1;
            cmd_o.issue_zero = st_i.conn;
          end
        endcase
      end
      ST_GAIN:   cmd_o.slot_gain = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_CURVE1: cmd_o.curve1 = 1'b1;
      ST_CURVE2: cmd_o.curve2 = 1'b1;
      ST_ACC:    begin cmd_o.acc = 1'b1; cmd_o.next_slot = 1'b1; end
      ST_SCALE1: begin cmd_o.scale1 = 1'b1; cmd_o.clear_exp = 1'b1; end
      ST_SCALE2: cmd_o.scale2 = 1'b1;
      ST_ISSUE:  cmd_o.issue_mix = 1'b1;
      ST_DONE:   cmd_o.out_load = !out_busy_i;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/core/rem_datapath.sv =====
// ----------------------------------------------------------------------------
// rem_datapath
// Slot store, gain unit with serial divider, accumulators and drive cache.
// ----------------------------------------------------------------------------
module rem_datapath import rem_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i,
  input  logic [1:0]    action_i,
  input  logic [1:0]    effect_kind_i,
  input  logic [47:0]   now_ms_i,
  input  logic          connected_i,
  input  logic [15:0]   manual_left_i,
  input  logic [15:0]   manual_right_i,
  input  logic [1:0]    manual_select_i,
  input  cmd_t          cmd_i,
  output status_t       st_o,
  output logic [15:0]   left_drive_o,
  output logic [15:0]   right_drive_o,
  output logic          sent_o,
  output logic          vibrating_o,
  output logic          manual_mode_o,
  output logic          rejected_o
);

  logic [7:0]  strength_q;
  logic [4:0]  enable_q;
  logic [63:0] prof_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= StrengthReset;
      enable_q   <= EnableReset;
      prof_q[0]  <= HitReset;
      prof_q[1]  <= HurtReset;
      prof_q[2]  <= FireReset;
      prof_q[3]  <= MeleeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STRENGTH: strength_q <= cfg_data_i[7:0];
        CFG_ENABLE:   enable_q   <= cfg_data_i[4:0];
        CFG_HIT:      prof_q[0]  <= cfg_data_i;
        CFG_HURT:     prof_q[1]  <= cfg_data_i;
        CFG_FIRE:     prof_q[2]  <= cfg_data_i;
        CFG_MELEE:    prof_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched input item.
  logic [1:0]  act_q, kind_q, sel_q;
  logic [TimeBits-1:0] now_q;
  logic        conn_q;
  logic [15:0] ml_q, mr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q  <= action_i;
      kind_q <= effect_kind_i;
      now_q  <= now_ms_i[TimeBits-1:0];
      conn_q <= connected_i;
      ml_q   <= manual_left_i;
      mr_q   <= manual_right_i;
      sel_q  <= manual_select_i;
    end
  end

  // Slot store.
  logic                active_q [SlotCount];
  logic [15:0]         sl_q [SlotCount];
  logic [15:0]         sr_q [SlotCount];
  logic [TimeBits-1:0] ss_q [SlotCount];
  logic [TimeBits-1:0] se_q [SlotCount];
  logic [15:0]         sf_q [SlotCount];
  logic [SlotBits-1:0] idx_q;

  logic [63:0] prof;
  logic [15:0] dur, fadev;
  logic [SlotBits-1:0] own, tgt;
  logic busy_own, found;

  always_comb begin
    prof  = prof_q[kind_q];
    dur   = prof[31:16];
    fadev = prof[15:0];
    unique case (kind_q)
      KIND_HIT:  own = SlotBits'(1);
      KIND_HURT: own = SlotBits'(2);
      KIND_FIRE: own = SlotBits'(0);
      default:   own = SlotBits'(3);
    endcase
    busy_own = (kind_q != KIND_FIRE) && active_q[own] && (now_q < se_q[own]);
    tgt   = own;
    found = 1'b0;
    if (busy_own) begin
      for (int k = SpareBegin; k < SlotCount; k++) begin
        if (!found && !active_q[k]) begin
          tgt   = SlotBits'(k);
          found = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SlotCount; k++) active_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < SlotCount; k++) begin
        if (cmd_i.clear_all) active_q[k] <= 1'b0;
        else if (cmd_i.clear_exp && active_q[k] && now_q >= se_q[k]) active_q[k] <= 1'b0;
      end
      if (cmd_i.store_slot) active_q[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_slot) begin
      sl_q[tgt] <= prof[63:48];
      sr_q[tgt] <= prof[47:32];
      ss_q[tgt] <= now_q;
      se_q[tgt] <= now_q + TimeBits'(dur);
      sf_q[tgt] <= (fadev < dur) ? fadev : dur;
    end
  end

  // Gain preconditions for the current slot.
  logic [TimeBits-1:0] c_end, c_fade, fstart;
  logic g_zero, g_full;
  always_comb begin
    c_end  = se_q[idx_q];
    c_fade = TimeBits'(sf_q[idx_q]);
    fstart = (c_end > c_fade) ? c_end - c_fade : ss_q[idx_q];
    g_zero = !active_q[idx_q] || now_q >= c_end;
    g_full = !g_zero && (sf_q[idx_q] == 16'd0 || now_q <= fstart);
  end

  // Serial restoring divider, one quotient bit per cycle.
  logic [TimeBits-1:0] num_q, den_q;
  logic [15:0]         quo_q;
  logic [4:0]          cnt_q;
  logic [GainBits-1:0] gain_q;
  logic                sat_q;
  logic [TimeBits-1:0] dmn;
  assign dmn = den_q - num_q;

  // Smoothstep: s = t*t*(3*65536-2t) >> 32.
  logic [15:0] t_v;
  logic [31:0] tt_q;
  logic [17:0] pw;
  logic [49:0] prod;
  logic [17:0] s_v;
  assign t_v  = sat_q ? 16'hFFFF : quo_q;
  assign pw   = 18'd196608 - {1'b0, t_v, 1'b0};
  assign prod = tt_q * pw;
  assign s_v  = prod[49:32];

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_gain) begin
      num_q  <= now_q - fstart;
      den_q  <= c_end - fstart;
      quo_q  <= '0;
      cnt_q  <= '0;
      sat_q  <= ((now_q - fstart) >= (c_end - fstart));
      gain_q <= g_zero ? '0 : GainBits'(65536);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 5'd1;
      if (num_q >= dmn) begin
        num_q <= num_q - dmn;
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        num_q <= num_q << 1;
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end else if (cmd_i.curve2) begin
      gain_q <= (s_v > 18'd65536) ? '0 : GainBits'(18'd65536 - s_v);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.curve1) tt_q <= t_v * t_v;
  end

  // Accumulate, scale, issue.
  logic [19:0] suml_q, sumr_q;
  logic [15:0] cl_q, cr_q, scl_q, scr_q;
  logic [23:0] ml_mul_q, mr_mul_q;
  logic        ovr_q, wasc_q, sent_q, rej_q;
  logic [32:0] cl_prod, cr_prod;
  assign cl_prod = sl_q[idx_q] * gain_q;
  assign cr_prod = sr_q[idx_q] * gain_q;

  function automatic logic [15:0] clamp20(logic [19:0] v);
    return (v > 20'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // Divide by 100 through a reciprocal multiply, exact for v below 2^30.
  function automatic logic [15:0] div100(logic [23:0] v);
    logic [49:0] p;
    logic [17:0] q;
    p = v * 26'd42949673;
    q = p[49:32];
    return (q > 18'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  logic [23:0] man_lp, man_rp;
  logic [15:0] man_l, man_r;
  assign man_lp = ml_q * strength_q;
  assign man_rp = mr_q * strength_q;
  assign man_l = sel_q[0] ? div100(man_lp) : cl_q;
  assign man_r = sel_q[1] ? div100(man_rp) : cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      cl_q   <= '0;
      cr_q   <= '0;
      ovr_q  <= 1'b0;
      wasc_q <= 1'b0;
      sent_q <= 1'b0;
      rej_q  <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        sent_q <= 1'b0;
        rej_q  <= 1'b0;
        idx_q  <= '0;
        wasc_q <= connected_i;
        if (wasc_q && !connected_i) begin
          cl_q <= '0;
          cr_q <= '0;
        end
      end
      if (cmd_i.next_slot) idx_q <= idx_q + SlotBits'(1);
      if (cmd_i.set_rej) rej_q <= 1'b1;
      if (cmd_i.set_ovr) ovr_q <= 1'b1;
      if (cmd_i.clr_ovr) ovr_q <= 1'b0;
      if (cmd_i.issue_manual && (man_l != cl_q || man_r != cr_q)) begin
        cl_q <= man_l; cr_q <= man_r; sent_q <= 1'b1;
      end
      if (cmd_i.issue_zero && (cl_q != '0 || cr_q != '0)) begin
        cl_q <= '0; cr_q <= '0; sent_q <= 1'b1;
      end
      if (cmd_i.issue_mix && (scl_q != cl_q || scr_q != cr_q)) begin
        cl_q <= scl_q; cr_q <= scr_q; sent_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_sum) begin
      suml_q <= '0;
      sumr_q <= '0;
    end else if (cmd_i.acc && gain_q != '0) begin
      suml_q <= suml_q + 20'(cl_prod[32:16]);
      sumr_q <= sumr_q + 20'(cr_prod[32:16]);
    end
    if (cmd_i.scale1) begin
      ml_mul_q <= clamp20(suml_q) * strength_q;
      mr_mul_q <= clamp20(sumr_q) * strength_q;
    end
    if (cmd_i.scale2) begin
      scl_q <= div100(ml_mul_q);
      scr_q <= div100(mr_mul_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      left_drive_o  <= cl_q;
      right_drive_o <= cr_q;
      sent_o        <= sent_q;
      vibrating_o   <= (cl_q != '0) || (cr_q != '0);
      manual_mode_o <= ovr_q;
      rejected_o    <= rej_q;
    end
  end

  always_comb begin
    st_o.action      = act_q;
    st_o.master      = enable_q[0];
    st_o.kind_on     = enable_q[{1'b0, kind_q} + 3'd1];
    st_o.conn        = conn_q;
    st_o.ovr         = ovr_q;
    st_o.gain_direct = g_zero || g_full;
    st_o.div_last    = (cnt_q == 5'd15);
    st_o.last_slot   = (idx_q == SlotBits'(SlotCount - 1));
  end

endmodule

// ===== tb/tb_rumble_effect_mixer_top.sv =====
// ----------------------------------------------------------------------------
// tb_rumble_effect_mixer_top
// Self-checking bench for the rumble effect mixer: directed corner cases,
// then random action streams under varying register settings and flow
// control and a long receiver hold, each result checked against an in-bench mixer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rumble_effect_mixer_top;
  import rem_pkg::*;

  localparam int SettleCycles = 200;  // outlasts the slowest item

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [1:0]  effect_kind_i = '0;
  logic [47:0] now_ms_i = '0;
  logic        connected_i = 1'b0;
  logic [15:0] manual_left_i = '0;
  logic [15:0] manual_right_i = '0;
  logic [1:0]  manual_select_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] left_drive_o;
  logic [15:0] right_drive_o;
  logic        sent_o;
  logic        vibrating_o;
  logic        manual_mode_o;
  logic        rejected_o;

  rumble_effect_mixer_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        sent;
    logic        vib;
    logic        manual;
    logic        rej;
  } drive_t;

  drive_t drive_q[$];
  int     fail_cnt = 0;
  int     src_idle = 0;
  int     sink_idle = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;

  // Mixer model state and registers.
  logic [7:0]  m_strength;
  logic [4:0]  m_enable;
  logic [63:0] m_profile[4];
  logic        s_active[SlotCount];
  logic [15:0] s_left[SlotCount];
  logic [15:0] s_right[SlotCount];
  logic [47:0] s_start[SlotCount];
  logic [47:0] s_end[SlotCount];
  logic [15:0] s_fade[SlotCount];
  logic [15:0] held_left, held_right;
  logic        ovr, was_conn;
  logic [47:0] clock_ms;

  function automatic longint unsigned frac_q16(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = 0;
    if (den == 0 || num >= den) return 65535;
    for (int i = 0; i < 16; i++) begin
      q = q << 1;
      if (num >= den - num) begin
        num = num - (den - num);
        q = q | 1;
      end else begin
        num = num << 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned slot_gain(int k, logic [47:0] now);
    longint unsigned fstart, t, s;
    if (!s_active[k] || now >= s_end[k]) return 0;
    if (s_fade[k] == 0) return 65536;
    fstart = (s_end[k] > s_fade[k]) ? s_end[k] - s_fade[k] : s_start[k];
    if (now <= fstart) return 65536;
    t = frac_q16(now - fstart, s_end[k] - fstart);
    s = ((t * t) * (3 * 65536 - 2 * t)) >> 32;
    if (s > 65536) s = 65536;
    return 65536 - s;
  endfunction

  function automatic logic [15:0] apply_strength(longint unsigned v);
    longint unsigned x;
    x = (v * m_strength) / 100;
    return (x > 65535) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic logic issue_drive(logic [15:0] l, logic [15:0] r);
    if (l == held_left && r == held_right) return 1'b0;
    held_left = l;
    held_right = r;
    return 1'b1;
  endfunction

  function automatic void drop_expired(logic [47:0] now);
    for (int k = 0; k < SlotCount; k++)
      if (s_active[k] && now >= s_end[k]) s_active[k] = 1'b0;
  endfunction

  function automatic logic mix_drive(logic [47:0] now, logic conn);
    longint unsigned l, r, g;
    l = 0;
    r = 0;
    if (ovr) return 1'b0;
    if (!conn) begin
      drop_expired(now);
      return 1'b0;
    end
    for (int k = 0; k < SlotCount; k++) begin
      g = slot_gain(k, now);
      if (g != 0) begin
        l += (s_left[k] * g) >> 16;
        r += (s_right[k] * g) >> 16;
      end
    end
    drop_expired(now);
    if (l > 65535) l = 65535;
    if (r > 65535) r = 65535;
    return issue_drive(apply_strength(l), apply_strength(r));
  endfunction

  // Advance the model by one accepted item and queue its result.
  function automatic void predict_drive(action_e a, logic [1:0] kind, logic [47:0] now,
                                        logic conn, logic [15:0] ml, logic [15:0] mr,
                                        logic [1:0] sel);
    drive_t d;
    logic sent, rej, master;
    logic [63:0] p;
    logic [15:0] dur, fade;
    int s;
    sent = 1'b0;
    rej = 1'b0;
    master = m_enable[0];
    if (was_conn && !conn) begin
      held_left = '0;
      held_right = '0;
    end
    was_conn = conn;
    case (a)
      ACT_TICK: begin
        if (master) sent = mix_drive(now, conn);
      end
      ACT_TRIGGER: begin
        if (!master || !m_enable[kind + 1] || !conn) begin
          rej = 1'b1;
        end else begin
          p = m_profile[kind];
          dur = p[31:16];
          fade = p[15:0];
          case (kind)
            KIND_HIT:  s = 1;
            KIND_HURT: s = 2;
            KIND_FIRE: s = 0;
            default:   s = 3;
          endcase
          if (kind != KIND_FIRE && s_active[s] && now < s_end[s]) begin
            for (int k = SpareBegin; k < SlotCount; k++)
              if (!s_active[k]) begin
                s = k;
                break;
              end
          end
          s_active[s] = 1'b1;
          s_left[s] = p[63:48];
          s_right[s] = p[47:32];
          s_start[s] = now;
          s_end[s] = now + dur;
          s_fade[s] = (fade < dur) ? fade : dur;
          sent = mix_drive(now, conn);
        end
      end
      ACT_MANUAL: begin
        if (!conn) begin
          rej = 1'b1;
        end else begin
          for (int k = 0; k < SlotCount; k++) s_active[k] = 1'b0;
          ovr = 1'b1;
          sent = issue_drive(sel[0] ? apply_strength(ml) : held_left,
                             sel[1] ? apply_strength(mr) : held_right);
        end
      end
      default: begin
        ovr = 1'b0;
        for (int k = 0; k < SlotCount; k++) s_active[k] = 1'b0;
        if (conn) sent = issue_drive('0, '0);
      end
    endcase
    d.left = held_left;
    d.right = held_right;
    d.sent = sent;
    d.vib = (held_left != 0) || (held_right != 0);
    d.manual = ovr;
    d.rej = rej;
    drive_q.push_back(d);
  endfunction

  // Offer one item, hold it until the transfer, then predict its result.
  task automatic send_action(action_e a, logic [1:0] kind, logic [47:0] now, logic conn,
                             logic [15:0] ml, logic [15:0] mr, logic [1:0] sel);
    if ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    action_i        <= a;
    effect_kind_i   <= kind;
    now_ms_i        <= now;
    connected_i     <= conn;
    manual_left_i   <= ml;
    manual_right_i  <= mr;
    manual_select_i <= sel;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_drive(a, kind, now, conn, ml, mr, sel);
  endtask

  // Drop valid, drain all results and let any trailing work finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_STRENGTH: m_strength = val[7:0];
      CFG_ENABLE:   m_enable = val[4:0];
      CFG_HIT:      m_profile[0] = val;
      CFG_HURT:     m_profile[1] = val;
      CFG_FIRE:     m_profile[2] = val;
      default:      m_profile[3] = val;
    endcase
  endtask

  function automatic logic [63:0] rand_profile();
    logic [15:0] dur, fade;
    dur = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    fade = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, dur));
    return {16'($urandom), 16'($urandom), dur, fade};
  endfunction

  // Compare each transfer against the oldest predicted drive.
  always @(posedge clk_i) begin
    drive_t exp_d, got;
    if (out_valid_o && !out_stall_i) begin
      got = {left_drive_o, right_drive_o, sent_o, vibrating_o, manual_mode_o, rejected_o};
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_cnt++;
      end else begin
        exp_d = drive_q.pop_front();
        if (got !== exp_d) begin
          $display("%0t: expected l=%h r=%h s=%b v=%b m=%b j=%b, got l=%h r=%h s=%b v=%b m=%b j=%b",
                   $time, exp_d.left, exp_d.right, exp_d.sent, exp_d.vib, exp_d.manual,
                   exp_d.rej, got.left, got.right, got.sent, got.vib, got.manual, got.rej);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver flow control: random stalls plus requested long holds.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle);
    end
  end

  task automatic test_directed();
    clock_ms = 48'd1000;
    send_action(ACT_TICK, 2'd0, clock_ms, 1'b1, '0, '0, 2'd3);
    // Each kind at reset profiles, impact slots stacking into spares.
    for (int k = 0; k < 4; k++)
      send_action(ACT_TRIGGER, 2'(k), clock_ms, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TRIGGER, 2'd0, clock_ms + 1, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TRIGGER, 2'd3, clock_ms + 2, 1'b1, '0, '0, 2'd0);
    for (int k = 0; k < 6; k++) send_action(ACT_TRIGGER, 2'd1, clock_ms + 3, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TICK, 2'd0, clock_ms + 100, 1'b1, '0, '0, 2'd0);
    // Disconnect edge on a tick, then trigger and manual while disconnected.
    send_action(ACT_TICK, 2'd0, clock_ms + 150, 1'b0, '0, '0, 2'd0);
    send_action(ACT_TRIGGER, 2'd2, clock_ms + 151, 1'b0, '0, '0, 2'd0);
    send_action(ACT_MANUAL, 2'd0, clock_ms + 152, 1'b0, 16'hFFFF, 16'hFFFF, 2'd3);
    // Manual: left only, right only and neither selected, trigger and tick while overridden, then stop.
    send_action(ACT_MANUAL, 2'd0, clock_ms + 153, 1'b1, 16'hFFFF, 16'h0000, 2'd1);
    send_action(ACT_MANUAL, 2'd0, clock_ms + 154, 1'b1, 16'h1234, 16'hFFFF, 2'd2);
    send_action(ACT_MANUAL, 2'd0, clock_ms + 155, 1'b1, 16'h0000, 16'h0000, 2'd0);
    send_action(ACT_TRIGGER, 2'd3, clock_ms + 156, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TICK, 2'd0, clock_ms + 157, 1'b1, '0, '0, 2'd0);
    send_action(ACT_STOP, 2'd0, clock_ms + 158, 1'b1, '0, '0, 2'd0);
    send_action(ACT_STOP, 2'd0, clock_ms + 159, 1'b1, '0, '0, 2'd0);
    // End time wraps past the top of the time range.
    send_action(ACT_TRIGGER, 2'd2, 48'hFFFF_FFFF_FFF0, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TICK, 2'd0, 48'hFFFF_FFFF_FFF1, 1'b1, '0, '0, 2'd0);
    // Master and kind enables off, strength 200 and zero, fade past duration.
    write_reg(CFG_ENABLE, 64'h0);
    send_action(ACT_TICK, 2'd0, 48'd5000, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TRIGGER, 2'd0, 48'd5000, 1'b1, '0, '0, 2'd0);
    write_reg(CFG_ENABLE, 64'h15);
    send_action(ACT_TRIGGER, 2'd0, 48'd5001, 1'b1, '0, '0, 2'd0);
    write_reg(CFG_STRENGTH, 64'd200);
    write_reg(CFG_HIT, {16'hFFFF, 16'hFFFF, 16'd10, 16'd500});
    write_reg(CFG_ENABLE, 64'h1F);
    send_action(ACT_TRIGGER, 2'd0, 48'd6000, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TICK, 2'd0, 48'd6005, 1'b1, '0, '0, 2'd0);
    write_reg(CFG_STRENGTH, 64'd0);
    send_action(ACT_TICK, 2'd0, 48'd6006, 1'b1, '0, '0, 2'd0);
    send_action(ACT_TICK, 2'd0, 48'd6020, 1'b1, '0, '0, 2'd0);
  endtask

  task automatic test_random(int n_items);
    action_e a;
    int pick;
    write_reg(CFG_STRENGTH, 64'($urandom_range(0, 200)));
    write_reg(CFG_ENABLE, ($urandom_range(3) == 0) ? 64'($urandom_range(0, 31)) : 64'd31);
    write_reg(CFG_HIT, rand_profile());
    write_reg(CFG_HURT, rand_profile());
    write_reg(CFG_FIRE, rand_profile());
    write_reg(CFG_MELEE, rand_profile());
    clock_ms = 48'({16'($urandom_range(0, 65535)), $urandom()} >> $urandom_range(0, 47));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      a = (pick < 55) ? ACT_TICK : (pick < 85) ? ACT_TRIGGER : (pick < 92) ? ACT_STOP
        : ACT_MANUAL;
      if ($urandom_range(99) == 0) clock_ms = {16'($urandom_range(0, 65535)), $urandom()};
      else clock_ms = clock_ms + 48'($urandom_range(0, 40));
      send_action(a, 2'($urandom), clock_ms, $urandom_range(99) < 95, 16'($urandom),
                  16'($urandom), 2'($urandom));
    end
  endtask

  // Hold the receiver off while the sender keeps offering items.
  task automatic test_backpressure();
    drain();
    src_idle = 0;
    hold_req++;
    for (int i = 0; i < 30; i++) begin
      clock_ms = clock_ms + 3;
      send_action((i % 3 == 0) ? ACT_TRIGGER : ACT_TICK, 2'($urandom), clock_ms, 1'b1,
                  '0, '0, 2'd0);
    end
  endtask

  initial begin
    m_strength = StrengthReset;
    m_enable = EnableReset;
    m_profile[0] = HitReset;
    m_profile[1] = HurtReset;
    m_profile[2] = FireReset;
    m_profile[3] = MeleeReset;
    for (int k = 0; k < SlotCount; k++) begin
      s_active[k] = 1'b0;
      s_left[k] = '0;
      s_right[k] = '0;
      s_start[k] = '0;
      s_end[k] = '0;
      s_fade[k] = '0;
    end
    held_left = '0;
    held_right = '0;
    ovr = 1'b0;
    was_conn = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    src_idle = 9;
    sink_idle = 87;
    for (int p = 0; p < 5; p++) test_random(100);
    src_idle = 87;
    sink_idle = 9;
    for (int p = 0; p < 5; p++) test_random(100);
    src_idle = 0;
    sink_idle = 0;
    for (int p = 0; p < 5; p++) test_random(100);
    test_backpressure();
    drain();
    if (fail_cnt == 0) $display("rumble_effect_mixer_top: match");
    else $display("rumble_effect_mixer_top: mismatch");
    $finish;
  end

  initial begin
    #60ms;
    $display("rumble_effect_mixer_top: mismatch");
    $finish;
  end

endmodule
